### rtl/glc_pkg.sv
package glc_pkg;

  // Field widths of the channel beats.
  localparam int IDX_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int DIM_W      = 7;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Width of pixel coordinates built from a byte index times eight.
  localparam int POS_W = IDX_W + 3;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_PIC_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIC_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE = 2'd2;

  // Register reset values.
  localparam logic [DIM_W-1:0]  PIC_WIDTH_RST   = 7'd16;
  localparam logic [DIM_W-1:0]  PIC_HEIGHT_RST  = 7'd16;

  // Conversion modes.
  localparam logic [MODE_W-1:0] MODE_PAGES   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COLVERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIRROR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COLHORZ = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TO_HORZ = 3'd4;

  // Input commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [MODE_W-1:0] mode_t;

endpackage

### rtl/glc_if.sv
interface glc_in_if import glc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  cmd;
  idx_t  byte_index;
  byte_t src_byte;

  modport source (output valid, cmd, byte_index, src_byte, input ready);
  modport sink   (input valid, cmd, byte_index, src_byte, output ready);
endinterface

interface glc_out_if import glc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  index_bad;

  modport source (output valid, out_byte, index_bad, input ready);
  modport sink   (input valid, out_byte, index_bad, output ready);
endinterface

interface glc_cfg_if import glc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/glc_ram.sv
module glc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/glyph_bitmap_layout_converter_core.sv
// A read beat with a bad index goes straight to the result state and a bad load is dropped;
// other beats run the 9-step divider, then a horizontal access reads one store row and
// writes it back or gathers a byte, and a vertical page reads eight rows, one store row
// per cycle; loads give no result beat. A new beat is taken only when the core is idle.
// Reset (synchronous, active low) restores width 16, height 16, mode 0 and empties the
// output register; the pixel store is not cleared and needs no clearing pass.
module glyph_bitmap_layout_converter_core import glc_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  glc_in_if.sink     in_ch,
  glc_out_if.source  out_ch,
  glc_cfg_if.sink    cfg_ch
);

  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int MW        = MAX_WIDTH;
  localparam int CNT_W     = 12;
  localparam int DIV_CNT_W = $clog2(IDX_W);

  localparam logic [DIM_W-1:0] W_CAP = (MAX_WIDTH > 127) ? 7'd127 : DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_CAP = (MAX_HEIGHT > 127) ? 7'd127 : DIM_W'(MAX_HEIGHT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_HRD  = 3'd2;
  localparam logic [2:0] S_HUSE = 3'd3;
  localparam logic [2:0] S_VCOL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Configuration registers.
  dim_t  pic_width_r, pic_height_r;
  mode_t layout_mode_r;

  // Control and payload registers.
  logic [2:0]           state_r, state_nxt;
  logic                 cmd_r, cmd_nxt;
  byte_t                sb_r, sb_nxt;
  idx_t                 quo_r, quo_nxt;
  dim_t                 rem_r, rem_nxt;
  dim_t                 div_r, div_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [3:0]           vb_r, vb_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [RW-1:0]        pend_row_r, pend_row_nxt;
  logic [2:0]           pend_bit_r, pend_bit_nxt;
  byte_t                acc_r, acc_nxt;
  byte_t                res_byte_r, res_byte_nxt;
  logic                 res_bad_r, res_bad_nxt;
  logic                 out_valid_r, out_valid_nxt;
  byte_t                out_byte_r, out_byte_nxt;
  logic                 out_bad_r, out_bad_nxt;

  // Pixel store port.
  logic          ram_rd_en, ram_wr_en;
  logic [RW-1:0] ram_rd_addr, ram_wr_addr;
  logic [MW-1:0] ram_rd_data, ram_wr_data;

  // Derived geometry.
  dim_t             w_eff, h_eff;
  logic [4:0]       wbyte, hbyte;
  logic [CNT_W-1:0] cnt_v, cnt_h, cnt_sel;
  logic             mode_ok, in_ok, in_ready, in_fire;
  dim_t             div_sel;

  // Divider step.
  logic [DIM_W:0] trial;
  logic           q_bit;

  // Coordinates of the current beat.
  logic             swap, horz_op;
  idx_t             major, minor;
  logic [POS_W-1:0] col_base, vrow, mir_sh;
  logic             vrow_ok;
  logic [CW-1:0]    col_j;

  // Row data paths.
  logic [MW-1:0] row_rev, row_src, row_sh, h_mask, h_data, h_merge, v_mask, v_merge;
  byte_t         mask8, data8, h_gather, acc_upd;

  // Saturate the size registers and count the destination bytes.
  always_comb begin
    w_eff = pic_width_r;
    if (pic_width_r == '0) begin
      w_eff = 7'd1;
    end else if (pic_width_r > W_CAP) begin
      w_eff = W_CAP;
    end
    h_eff = pic_height_r;
    if (pic_height_r == '0) begin
      h_eff = 7'd1;
    end else if (pic_height_r > H_CAP) begin
      h_eff = H_CAP;
    end
  end

  assign wbyte = 5'(({1'b0, w_eff} + 8'd7) >> 3);
  assign hbyte = 5'(({1'b0, h_eff} + 8'd7) >> 3);
  assign cnt_v = CNT_W'(hbyte) * CNT_W'(w_eff);
  assign cnt_h = CNT_W'(wbyte) * CNT_W'(h_eff);

  // Index check and divisor choice for an arriving beat.
  always_comb begin
    mode_ok = (layout_mode_r == MODE_PAGES) || (layout_mode_r == MODE_COLVERT) ||
              (layout_mode_r == MODE_MIRROR) || (layout_mode_r == MODE_COLHORZ) ||
              (layout_mode_r == MODE_TO_HORZ);
    if (in_ch.cmd == CMD_LOAD) begin
      cnt_sel = (layout_mode_r == MODE_TO_HORZ) ? cnt_v : cnt_h;
      div_sel = (layout_mode_r == MODE_TO_HORZ) ? w_eff : DIM_W'(wbyte);
    end else begin
      case (layout_mode_r)
        MODE_PAGES: begin
          cnt_sel = cnt_v;
          div_sel = w_eff;
        end
        MODE_COLVERT: begin
          cnt_sel = cnt_v;
          div_sel = DIM_W'(hbyte);
        end
        MODE_COLHORZ: begin
          cnt_sel = cnt_h;
          div_sel = h_eff;
        end
        default: begin
          cnt_sel = cnt_h;
          div_sel = DIM_W'(wbyte);
        end
      endcase
    end
    in_ok = mode_ok && (CNT_W'(in_ch.byte_index) < cnt_sel);
  end

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // One restoring divide step per cycle.
  assign trial = {rem_r, quo_r[IDX_W-1]};
  assign q_bit = (trial >= {1'b0, div_r});

  // Column-major reads take the remainder as the outer coordinate.
  always_comb begin
    swap    = (cmd_r == CMD_READ) &&
              ((layout_mode_r == MODE_COLVERT) || (layout_mode_r == MODE_COLHORZ));
    horz_op = (cmd_r == CMD_LOAD) ? (layout_mode_r != MODE_TO_HORZ) :
              ((layout_mode_r == MODE_MIRROR) || (layout_mode_r == MODE_COLHORZ) ||
               (layout_mode_r == MODE_TO_HORZ));
    major   = swap ? IDX_W'(rem_r) : quo_r;
    minor   = swap ? quo_r : IDX_W'(rem_r);
  end

  assign col_base = {minor, 3'b000};
  assign vrow     = {major, 3'b000} + POS_W'(vb_r);
  assign vrow_ok  = (vrow < POS_W'(h_eff));
  assign col_j    = minor[CW-1:0];
  assign mir_sh   = POS_W'(MAX_WIDTH) - POS_W'(w_eff);

  // Horizontal byte: bit 7-k is column col_base+k, mirrored about the glyph width for reads in mode 2.
  always_comb begin
    for (int c = 0; c < MW; c++) begin
      row_rev[c] = ram_rd_data[MW-1-c];
    end
    row_src = (layout_mode_r == MODE_MIRROR) ? (row_rev >> mir_sh) : ram_rd_data;
    row_sh  = row_src >> col_base;
    for (int k = 0; k < 8; k++) begin
      mask8[k]      = ((col_base + POS_W'(k)) < POS_W'(w_eff));
      data8[k]      = sb_r[7-k];
      h_gather[7-k] = row_sh[k] & mask8[k];
    end
    h_mask  = MW'(mask8) << col_base;
    h_data  = MW'(data8) << col_base;
    h_merge = (ram_rd_data & ~h_mask) | (h_data & h_mask);
  end

  // Vertical page: one pixel of column j per row.
  always_comb begin
    v_mask  = MW'(1) << col_j;
    v_merge = (ram_rd_data & ~v_mask) | (sb_r[pend_bit_r] ? v_mask : '0);
    acc_upd = acc_r;
    if (pend_valid_r && ram_rd_data[col_j]) begin
      acc_upd = acc_r | (8'd1 << pend_bit_r);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    sb_nxt         = sb_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    div_cnt_nxt    = div_cnt_r;
    vb_nxt         = vb_r;
    pend_valid_nxt = pend_valid_r;
    pend_row_nxt   = pend_row_r;
    pend_bit_nxt   = pend_bit_r;
    acc_nxt        = acc_r;
    res_byte_nxt   = res_byte_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_bad_nxt    = out_bad_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = major[RW-1:0];
    ram_wr_en      = 1'b0;
    ram_wr_addr    = major[RW-1:0];
    ram_wr_data    = h_merge;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_ch.cmd;
          sb_nxt  = in_ch.src_byte;
          if (!in_ok) begin
            // A bad read answers at once; a bad load is dropped.
            if (in_ch.cmd == CMD_READ) begin
              res_byte_nxt = '0;
              res_bad_nxt  = 1'b1;
              state_nxt    = S_DONE;
            end
          end else begin
            quo_nxt     = in_ch.byte_index;
            rem_nxt     = '0;
            div_nxt     = div_sel;
            div_cnt_nxt = '0;
            res_bad_nxt = 1'b0;
            state_nxt   = S_DIV;
          end
        end
      end
      S_DIV: begin
        quo_nxt     = {quo_r[IDX_W-2:0], q_bit};
        rem_nxt     = q_bit ? DIM_W'(trial - {1'b0, div_r}) : DIM_W'(trial);
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(IDX_W - 1)) begin
          vb_nxt         = '0;
          pend_valid_nxt = 1'b0;
          acc_nxt        = '0;
          state_nxt      = horz_op ? S_HRD : S_VCOL;
        end
      end
      S_HRD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_HUSE;
      end
      S_HUSE: begin
        if (cmd_r == CMD_LOAD) begin
          ram_wr_en = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          res_byte_nxt = h_gather;
          state_nxt    = S_DONE;
        end
      end
      S_VCOL: begin
        // Read row vb while the row read last cycle is written back or gathered.
        if (!vb_r[3]) begin
          ram_rd_en      = vrow_ok;
          ram_rd_addr    = vrow[RW-1:0];
          pend_valid_nxt = vrow_ok;
          pend_row_nxt   = vrow[RW-1:0];
          pend_bit_nxt   = vb_r[2:0];
          vb_nxt         = vb_r + 4'd1;
        end else begin
          pend_valid_nxt = 1'b0;
          res_byte_nxt   = acc_upd;
          state_nxt      = (cmd_r == CMD_LOAD) ? S_IDLE : S_DONE;
        end
        if (pend_valid_r) begin
          if (cmd_r == CMD_LOAD) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pend_row_r;
            ram_wr_data = v_merge;
          end else begin
            acc_nxt = acc_upd;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_byte_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      pend_valid_r  <= 1'b0;
      pic_width_r   <= PIC_WIDTH_RST;
      pic_height_r  <= PIC_HEIGHT_RST;
      layout_mode_r <= MODE_PAGES;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.reg_index)
          REG_PIC_WIDTH:   pic_width_r   <= cfg_ch.wdata;
          REG_PIC_HEIGHT:  pic_height_r  <= cfg_ch.wdata;
          REG_LAYOUT_MODE: layout_mode_r <= cfg_ch.wdata[MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    sb_r       <= sb_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    div_cnt_r  <= div_cnt_nxt;
    vb_r       <= vb_nxt;
    pend_row_r <= pend_row_nxt;
    pend_bit_r <= pend_bit_nxt;
    acc_r      <= acc_nxt;
    res_byte_r <= res_byte_nxt;
    res_bad_r  <= res_bad_nxt;
    out_byte_r <= out_byte_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.index_bad = out_bad_r;

  // Pixel store: one row of pixels per entry, bit c is column c.
  glc_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_pixel_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

endmodule
